[design/led_matrix_glyph_transpose_scroll_top_assert.svh]
// ----------------------------------------------------------------------------
// led matrix glyph transpose scroll assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_GLYPH_TRANSPOSE_SCROLL_TOP_ASSERT_SVH
`define LED_MATRIX_GLYPH_TRANSPOSE_SCROLL_TOP_ASSERT_SVH

// same-cycle implication
`define LMGT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmgt assertion failed");

// next-cycle implication
`define LMGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmgt assertion failed");

`endif

[design/lmgt_pkg.sv]
// ----------------------------------------------------------------------------
// lmgt_pkg
// constants, codes and control types shared by the glyph transpose scroll block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmgt_pkg;

  localparam int GLYPH_SLOTS   = 4;
  localparam int CHAIN_DEVICES = 4;

  localparam int STORE_BYTES  = GLYPH_SLOTS * 32;
  localparam int STORE_BLOCKS = GLYPH_SLOTS * 4;
  localparam int ROW_W        = $clog2(STORE_BLOCKS);
  localparam int DEV_W        = (CHAIN_DEVICES > 1) ? $clog2(CHAIN_DEVICES) : 1;

  // function codes of an input beat
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_RENDER = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_RN_RD,
    S_RN_OUT
  } lmgt_state_t;

  typedef struct packed {
    logic in_ready;
    logic cap;
    logic clr;
    logic rd_en;
    logic rd_render;
    logic wr_en;
    logic cnt_clr;
    logic out_load;
  } lmgt_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_func;
    logic       out_free;
    logic       word_last;
  } lmgt_sts_t;

endpackage

[design/lmgt_if.sv]
// ----------------------------------------------------------------------------
// lmgt channel interfaces
// valid/ready channels for input beats and rendered word beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmgt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] glyph_slot;
  logic [4:0] byte_index;
  logic [7:0] data_byte;
  logic       narrow_chars;
  logic [3:0] shift_amount;
  logic       shift_right;

  modport source (
    output valid, func, glyph_slot, byte_index, data_byte, narrow_chars,
           shift_amount, shift_right,
    input  ready
  );
  modport sink (
    input  valid, func, glyph_slot, byte_index, data_byte, narrow_chars,
           shift_amount, shift_right,
    output ready
  );
endinterface

interface lmgt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic [1:0] device;
  logic [7:0] seg_data;
  logic       chain_end;
  logic       last;

  modport source (
    output valid, digit, device, seg_data, chain_end, last,
    input  ready
  );
  modport sink (
    input  valid, digit, device, seg_data, chain_end, last,
    output ready
  );
endinterface

[design/lmgt_ctrl.sv]
// ----------------------------------------------------------------------------
// lmgt_ctrl
// sequencer for load read-modify-write, clear and the 32-word render walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "led_matrix_glyph_transpose_scroll_top_assert.svh"

module lmgt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  lmgt_pkg::lmgt_sts_t sts,
  output lmgt_pkg::lmgt_cmd_t cmd
);

  lmgt_pkg::lmgt_state_t state_r;
  lmgt_pkg::lmgt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmgt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmgt_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          if (sts.in_func == lmgt_pkg::FUNC_LOAD) begin
            state_nxt = lmgt_pkg::S_LD_RD;
          end else if (sts.in_func == lmgt_pkg::FUNC_RENDER) begin
            state_nxt = lmgt_pkg::S_RN_RD;
          end
        end
      end
      lmgt_pkg::S_LD_RD:  state_nxt = lmgt_pkg::S_LD_WR;
      lmgt_pkg::S_LD_WR:  state_nxt = lmgt_pkg::S_IDLE;
      lmgt_pkg::S_RN_RD:  state_nxt = lmgt_pkg::S_RN_OUT;
      lmgt_pkg::S_RN_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.word_last ? lmgt_pkg::S_IDLE : lmgt_pkg::S_RN_RD;
        end
      end
      default: state_nxt = lmgt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      lmgt_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.cap     = 1'b1;
          cmd.clr     = (sts.in_func == lmgt_pkg::FUNC_CLEAR);
          cmd.cnt_clr = (sts.in_func == lmgt_pkg::FUNC_RENDER);
        end
      end
      lmgt_pkg::S_LD_RD: begin
        cmd.rd_en = 1'b1;
      end
      lmgt_pkg::S_LD_WR: begin
        cmd.wr_en = 1'b1;
      end
      lmgt_pkg::S_RN_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_render = 1'b1;
      end
      lmgt_pkg::S_RN_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  `LMGT_ASSERT_IMPLY(a_load_needs_room, cmd.out_load, sts.out_free)
  `LMGT_ASSERT_NEXT(a_read_then_write, cmd.rd_en && !cmd.rd_render, cmd.wr_en)
  `LMGT_ASSERT_NEXT(a_frame_ends_idle, cmd.out_load && sts.word_last,
                    cmd.in_ready)
  `LMGT_ASSERT_NEXT(a_render_starts_read,
                    cmd.cap && sts.in_func == lmgt_pkg::FUNC_RENDER,
                    cmd.rd_en && cmd.rd_render)

endmodule

[design/lmgt_dp.sv]
// ----------------------------------------------------------------------------
// lmgt_dp
// item registers, row-wide glyph store, transpose write, word counters, output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmgt_dp (
  input  logic                clk,
  input  logic                rst_n,
  lmgt_in_if.sink             in_ch,
  lmgt_out_if.source          out_ch,
  input  lmgt_pkg::lmgt_cmd_t cmd,
  output lmgt_pkg::lmgt_sts_t sts
);

  // slot wraps modulo the slot count
  function automatic logic [1:0] slot_wrap(input logic [1:0] s);
    logic [2:0] v;
    v = {1'b0, s};
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= lmgt_pkg::GLYPH_SLOTS) begin
        v = v - 3'(lmgt_pkg::GLYPH_SLOTS);
      end
    end
    return v[1:0];
  endfunction

  function automatic logic [lmgt_pkg::ROW_W-1:0] render_row(
    input logic [1:0] s, input logic [lmgt_pkg::DEV_W-1:0] dev);
    int v;
    v = int'(s) * 4 + 3 - int'(dev);
    if (v < 0) v = v + lmgt_pkg::STORE_BLOCKS;
    if (v < 0) v = v + lmgt_pkg::STORE_BLOCKS;
    return lmgt_pkg::ROW_W'(v);
  endfunction

  logic [1:0] slot_r;
  logic [4:0] idx_r;
  logic [7:0] data_r;
  logic       narrow_r;
  logic [3:0] sh_r;
  logic       right_r;

  logic [63:0]                     mem [lmgt_pkg::STORE_BLOCKS];
  logic [lmgt_pkg::STORE_BLOCKS-1:0] valid_r;
  logic [63:0]                     rd_data_r;

  logic [2:0]                digit_r;
  logic [lmgt_pkg::DEV_W-1:0] dev_r;
  logic                      dev_last;

  logic       out_valid_r;
  logic [3:0] out_digit_r;
  logic [1:0] out_device_r;
  logic [7:0] out_seg_r;
  logic       out_chain_end_r;
  logic       out_last_r;

  logic [1:0]                blk;
  logic [lmgt_pkg::ROW_W-1:0] ld_row;
  logic [lmgt_pkg::ROW_W-1:0] rn_row;
  logic [lmgt_pkg::ROW_W-1:0] rd_addr;
  logic [63:0]               row_new;
  logic [7:0]                row_byte;
  logic [7:0]                seg;

  assign in_ch.ready   = cmd.in_ready;
  assign sts.in_valid  = in_ch.valid;
  assign sts.in_func   = in_ch.func;
  assign sts.out_free  = !out_valid_r || out_ch.ready;
  assign dev_last      = (dev_r == lmgt_pkg::DEV_W'(lmgt_pkg::CHAIN_DEVICES - 1));
  assign sts.word_last = dev_last && (digit_r == 3'd7);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      slot_r   <= slot_wrap(in_ch.glyph_slot);
      idx_r    <= in_ch.byte_index;
      data_r   <= in_ch.data_byte;
      narrow_r <= in_ch.narrow_chars;
      sh_r     <= in_ch.shift_amount;
      right_r  <= in_ch.shift_right;
    end
  end

  // 16x16 mode swaps the two middle blocks
  always_comb begin
    blk = idx_r[4:3];
    if (!narrow_r && (blk == 2'd1 || blk == 2'd2)) begin
      blk = blk ^ 2'd3;
    end
    ld_row  = lmgt_pkg::ROW_W'(int'(slot_r) * 4 + int'(blk));
    rn_row  = render_row(slot_r, dev_r);
    rd_addr = cmd.rd_render ? rn_row : ld_row;
  end

  // transpose: bit k of the font byte goes to bit 7-col of row byte k
  always_comb begin
    row_new = rd_data_r;
    for (int k = 0; k < 8; k++) begin
      row_new[8 * k + 7 - int'(idx_r[2:0])] = data_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : 64'd0;
    end
    if (cmd.wr_en) begin
      mem[ld_row] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[ld_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      digit_r <= '0;
      dev_r   <= '0;
    end else if (cmd.out_load) begin
      if (dev_last) begin
        dev_r   <= '0;
        digit_r <= digit_r + 3'd1;
      end else begin
        dev_r <= dev_r + lmgt_pkg::DEV_W'(1);
      end
    end
  end

  assign row_byte = rd_data_r[{digit_r, 3'b000} +: 8];
  assign seg      = right_r ? (row_byte >> sh_r) : (row_byte << sh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_digit_r     <= {1'b0, digit_r} + 4'd1;
      out_device_r    <= 2'(dev_r);
      out_seg_r       <= seg;
      out_chain_end_r <= dev_last;
      out_last_r      <= sts.word_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.digit     = out_digit_r;
  assign out_ch.device    = out_device_r;
  assign out_ch.seg_data  = out_seg_r;
  assign out_ch.chain_end = out_chain_end_r;
  assign out_ch.last      = out_last_r;

endmodule

[design/led_matrix_glyph_transpose_scroll_top.sv]
// load beat: accepted in idle, store row read then rewritten, next beat once back in idle
// clear beat: all row valid flags drop at once, next beat on the following cycle
// render beat: per word a store read, then an output load that waits for a free output register
// a render frame is 32 words; the next beat is accepted once its last word is loaded
// reset: synchronous active low, store reads as all zero at once, no clearing pass
// ----------------------------------------------------------------------------
// led_matrix_glyph_transpose_scroll_top
// transposing glyph frame store with scrolled word output for chained 8x8 drivers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_glyph_transpose_scroll_top (
  input  logic       clk,
  input  logic       rst_n,
  lmgt_in_if.sink    in_ch,
  lmgt_out_if.source out_ch
);

  // controller and datapath talk only through these two bundles
  lmgt_pkg::lmgt_cmd_t cmd;
  lmgt_pkg::lmgt_sts_t sts;

  // sequencer: idle accepts a beat, load does read-modify-write of one row,
  // render walks digit outer and device inner with a read then a capture
  lmgt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: each store row holds one 8-byte block, row-major, with a
  // valid flag so that an unwritten or cleared row reads as zero; the output
  // word register lets the next beat in while a word waits downstream
  lmgt_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

[tb/sv/led_matrix_glyph_transpose_scroll_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_glyph_transpose_scroll_top_tb
// self-checking bench: font byte loads, store clears and frame renders go in on
// a bursty valid/ready channel, a scoreboard of the transposed glyph store
// predicts each 32-word frame, and every word beat is compared field by field
// ----------------------------------------------------------------------------

module led_matrix_glyph_transpose_scroll_top_tb;
  import lmgt_pkg::*;

  // unused function code, the block drops it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // lets a load finish rewriting its row
  localparam int STUCK_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int RANDOM_ITEMS  = 456;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] slot;
    logic [4:0] idx;
    logic [7:0] data;
    logic       narrow;
    logic [3:0] amt;
    logic       right;
  } beat_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [1:0] device;
    logic [7:0] seg_data;
    logic       chain_end;
    logic       last;
  } drv_word_t;

  // one directed row: the beat, plus a seg_data value every word of the
  // frame must carry when it is obvious (empty store, shift of 8 or more)
  typedef struct packed {
    beat_t      beat;
    logic       known;
    logic [7:0] kval;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  localparam dir_row_t DIRECTED [24] = '{
    // empty store after reset, then the largest shift code
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd0,  1'b0}, 1'b1, 8'h00},
    '{'{FUNC_RENDER, 2'd3, 5'd31, 8'hff, 1'b1, 4'd15, 1'b1}, 1'b1, 8'h00},
    // loads at the edges of a glyph, both block orders
    '{'{FUNC_LOAD,   2'd0, 5'd0,  8'hff, 1'b1, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd0, 5'd7,  8'h80, 1'b1, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd0, 5'd8,  8'h01, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd0, 5'd16, 8'haa, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd0, 5'd31, 8'h55, 1'b1, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd3, 5'd15, 8'hff, 1'b1, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_LOAD,   2'd3, 5'd24, 8'h3c, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    // unused code, must leave no trace
    '{'{FUNC_UNUSED, 2'd1, 5'd5,  8'hff, 1'b1, 4'd8,  1'b1}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd8,  1'b0}, 1'b1, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd8,  1'b1}, 1'b1, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd3,  1'b1}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd5,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd3, 5'd0,  8'h00, 1'b0, 4'd1,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd3, 5'd0,  8'h00, 1'b0, 4'd9,  1'b0}, 1'b1, 8'h00},
    '{'{FUNC_LOAD,   2'd1, 5'd20, 8'h81, 1'b1, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd1, 5'd0,  8'h00, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    // clear wipes every slot
    '{'{FUNC_CLEAR,  2'd2, 5'd9,  8'h7e, 1'b1, 4'd2,  1'b1}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd0, 5'd0,  8'h00, 1'b0, 4'd0,  1'b0}, 1'b1, 8'h00},
    '{'{FUNC_RENDER, 2'd3, 5'd0,  8'h00, 1'b0, 4'd7,  1'b1}, 1'b1, 8'h00},
    '{'{FUNC_LOAD,   2'd2, 5'd12, 8'h0f, 1'b0, 4'd0,  1'b0}, 1'b0, 8'h00},
    '{'{FUNC_RENDER, 2'd2, 5'd0,  8'h00, 1'b0, 4'd2,  1'b1}, 1'b0, 8'h00}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lmgt_in_if  in_ch ();
  lmgt_out_if out_ch ();

  led_matrix_glyph_transpose_scroll_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scoreboard state: row-major copy of the glyph store and the words owed
  logic [7:0] glyph_rows [STORE_BYTES];
  drv_word_t  owed_words [$];
  logic       frame_known [$];   // one entry per render beat, in send order
  logic [7:0] frame_kval [$];

  int mismatch_count = 0;
  int words_seen     = 0;
  int stuck_cycles   = 0;

  // sender bookkeeping
  int   burst_left  = 0;
  int   items_sent  = 0;
  logic offering    = 1'b0;
  logic steady_send = 1'b0;

  // receiver hold-off handshake between the stimulus and the receiver
  int hold_reqs  = 0;
  int hold_taken = 0;

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) glyph_rows[i] = 8'h00;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch %s: got %0d want %0d (word %0d, t=%0t)", what, got, want,
               words_seen, $time);
  endtask

  // scatter one column-major font byte into the row-major store
  function automatic void store_font_byte(beat_t b);
    int unsigned blk;
    int unsigned base;
    int unsigned col;
    blk = b.idx[4:3];
    col = b.idx[2:0];
    if (!b.narrow && (blk == 1 || blk == 2)) blk = blk ^ 3;
    base = (b.slot % GLYPH_SLOTS) * 32 + blk * 8;
    for (int k = 0; k < 8; k++) glyph_rows[base + k][7 - col] = b.data[k];
  endfunction

  // queue the 32 driver words a render beat owes, digit outer, device inner
  function automatic void expand_frame(beat_t b, logic known, logic [7:0] kval);
    int unsigned sh;
    int unsigned blk;
    int unsigned row;
    drv_word_t   w;
    sh = (b.amt > 8) ? 8 : b.amt;
    for (int d = 1; d <= 8; d++) begin
      for (int j = 0; j < CHAIN_DEVICES; j++) begin
        blk = ((b.slot % GLYPH_SLOTS) * 4 + 3 + STORE_BLOCKS * 8 - j) % STORE_BLOCKS;
        row = glyph_rows[blk * 8 + d - 1];
        w.digit     = d[3:0];
        w.device    = j[1:0];
        w.seg_data  = b.right ? 8'(row >> sh) : 8'(row << sh);
        if (known) w.seg_data = kval;
        w.chain_end = (j == CHAIN_DEVICES - 1);
        w.last      = (d == 8) && (j == CHAIN_DEVICES - 1);
        owed_words.push_back(w);
      end
    end
  endfunction

  function automatic void take_beat(beat_t b);
    logic known;
    logic [7:0] kval;
    case (b.func)
      FUNC_LOAD: begin
        store_font_byte(b);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) glyph_rows[i] = 8'h00;
      end
      FUNC_RENDER: begin
        known = 1'b0;
        kval  = 8'h00;
        if (frame_known.size() != 0) begin
          known = frame_known.pop_front();
          kval  = frame_kval.pop_front();
        end
        expand_frame(b, known, kval);
      end
      default: begin
        // unused code: nothing happens
      end
    endcase
  endfunction

  task automatic check_word(drv_word_t got);
    drv_word_t want;
    words_seen++;
    if (owed_words.size() == 0) begin
      report_mismatch("word with nothing owed, seg_data", got.seg_data, 0);
      return;
    end
    want = owed_words.pop_front();
    if (got.digit != want.digit)         report_mismatch("digit", got.digit, want.digit);
    if (got.device != want.device)       report_mismatch("device", got.device, want.device);
    if (got.seg_data != want.seg_data)   report_mismatch("seg_data", got.seg_data, want.seg_data);
    if (got.chain_end != want.chain_end)
      report_mismatch("chain_end", got.chain_end, want.chain_end);
    if (got.last != want.last)           report_mismatch("last", got.last, want.last);
  endtask

  // monitor: sample both channels at the edge, word side first so a word
  // can never be matched against a frame accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        check_word('{out_ch.digit, out_ch.device, out_ch.seg_data, out_ch.chain_end,
                     out_ch.last});
      if (in_ch.valid && in_ch.ready)
        take_beat('{in_ch.func, in_ch.glyph_slot, in_ch.byte_index, in_ch.data_byte,
                    in_ch.narrow_chars, in_ch.shift_amount, in_ch.shift_right});
    end
  end

  // watchdog: no beat on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d words owed", stuck_cycles,
                 owed_words.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: changes its stall pattern every so often, and takes a long
  // hold-off whenever the stimulus asks for one
  rx_mode_t    rx_mode       = RX_STEADY;
  int          rx_phase_left = 0;
  int          hold_left     = 0;
  logic [1:0]  rx_tick       = 2'd0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(16, 160);
      end else begin
        rx_phase_left--;
      end
      rx_tick = rx_tick + 2'd1;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY:   out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ch.ready <= (rx_tick != 2'd3);
          default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic lower_valid();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one beat, with a random gap in front of it at the start of a burst
  task automatic send_beat(beat_t b, logic known, logic [7:0] kval);
    int gap;
    if (b.func == FUNC_RENDER) begin
      frame_known.push_back(known);
      frame_kval.push_back(kval);
    end
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) begin
          lower_valid();
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= b.func;
    in_ch.glyph_slot   <= b.slot;
    in_ch.byte_index   <= b.idx;
    in_ch.data_byte    <= b.data;
    in_ch.narrow_chars <= b.narrow;
    in_ch.shift_amount <= b.amt;
    in_ch.shift_right  <= b.right;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (b.func != FUNC_UNUSED) items_sent++;
  endtask

  // stop offering until every owed word is out and any load has settled
  task automatic wait_drained();
    lower_valid();
    do @(posedge clk); while (owed_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic beat_t rand_beat(logic [1:0] func);
    beat_t b;
    b.func   = func;
    b.slot   = 2'($urandom_range(0, 3));
    b.idx    = 5'($urandom_range(0, 31));
    b.data   = 8'($urandom_range(0, 255));
    b.narrow = 1'($urandom_range(0, 1));
    b.amt    = 4'($urandom_range(0, 15));
    b.right  = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // receiver holds off while the sender keeps pushing frames and loads
  // back to back, so the block backs up and stalls its input
  task automatic squeeze_block();
    hold_reqs++;
    steady_send = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_beat(rand_beat(FUNC_RENDER), 1'b0, 8'h00);
      send_beat(rand_beat(FUNC_LOAD), 1'b0, 8'h00);
      send_beat(rand_beat(FUNC_LOAD), 1'b0, 8'h00);
    end
    steady_send = 1'b0;
  endtask

  // typical use: fill one glyph (whole or in part) and show it a few times;
  // now and then the block order flips halfway or another slot is shown
  task automatic fill_and_show();
    beat_t b;
    int    n;
    int    shows;
    logic  broken;
    b      = rand_beat(FUNC_LOAD);
    broken = ($urandom_range(0, 7) == 0);
    n      = ($urandom_range(0, 1) == 1) ? 32 : $urandom_range(4, 16);
    for (int i = 0; i < n; i++) begin
      b.idx  = (n == 32) ? i[4:0] : 5'($urandom_range(0, 31));
      b.data = 8'($urandom_range(0, 255));
      if (broken && i == n / 2) b.narrow = ~b.narrow;
      send_beat(b, 1'b0, 8'h00);
    end
    b.func = FUNC_RENDER;
    if (broken) b.slot = 2'($urandom_range(0, 3));
    shows = $urandom_range(1, 3);
    for (int i = 0; i < shows; i++) begin
      b.amt   = 4'($urandom_range(0, 15));
      b.right = 1'($urandom_range(0, 1));
      b.idx   = 5'($urandom_range(0, 31));
      b.data  = 8'($urandom_range(0, 255));
      send_beat(b, 1'b0, 8'h00);
    end
  endtask

  initial begin
    int   pick;
    logic mid_squeeze_done;
    mid_squeeze_done = 1'b0;

    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_LOAD;
    in_ch.glyph_slot   <= 2'd0;
    in_ch.byte_index   <= 5'd0;
    in_ch.data_byte    <= 8'h00;
    in_ch.narrow_chars <= 1'b0;
    in_ch.shift_amount <= 4'd0;
    in_ch.shift_right  <= 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int r = 0; r < $size(DIRECTED); r++)
      send_beat(DIRECTED[r].beat, DIRECTED[r].known, DIRECTED[r].kval);
    wait_drained();

    // random part, opened with a backed-up block
    items_sent = 0;
    squeeze_block();
    while (items_sent < RANDOM_ITEMS) begin
      if (!mid_squeeze_done && items_sent > RANDOM_ITEMS / 2) begin
        mid_squeeze_done = 1'b1;
        squeeze_block();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        fill_and_show();
      else if (pick < 70)
        send_beat(rand_beat(FUNC_RENDER), 1'b0, 8'h00);
      else if (pick < 82)
        send_beat(rand_beat(FUNC_LOAD), 1'b0, 8'h00);
      else if (pick < 87)
        send_beat(rand_beat(FUNC_CLEAR), 1'b0, 8'h00);
      else if (pick < 94)
        send_beat(rand_beat(FUNC_UNUSED), 1'b0, 8'h00);
      else
        wait_drained();
    end

    wait_drained();
    if (owed_words.size() != 0)
      report_mismatch("words still owed at end", owed_words.size(), 0);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/lmgt_pkg.sv
design/lmgt_if.sv
design/lmgt_ctrl.sv
design/lmgt_dp.sv
design/led_matrix_glyph_transpose_scroll_top.sv
tb/sv/led_matrix_glyph_transpose_scroll_top_tb.sv
